// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/srm_pkg.sv =====
// Types and constants for the SPI radio access master.
// No dependencies.
`timescale 1ns / 1ps

package srm_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;

	localparam logic [2:0] KIND_REG     = 3'd0;
	localparam logic [2:0] KIND_EXT     = 3'd1;
	localparam logic [2:0] KIND_STROBE  = 3'd2;
	localparam logic [2:0] KIND_DIRFIFO = 3'd3;
	localparam logic [2:0] KIND_STDFIFO = 3'd4;

	localparam logic [1:0] REG_EXT_CODE = 2'd0;
	localparam logic [1:0] REG_DIR_CODE = 2'd1;
	localparam logic [1:0] REG_STD_CODE = 2'd2;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_LOAD  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_HEAD  = 5'b00010,
		PH_ADDR  = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_WAITW = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [5:0] ext_code;
		logic [5:0] dir_code;
		logic [5:0] std_code;
	} cfg_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] kind;
		logic       rd;
		logic [7:0] head;
		logic [7:0] addr;
		logic [7:0] count;
		logic [7:0] wbyte;
		logic       miso;
	} item_t;

	typedef struct packed {
		logic       sclk;
		logic       mosi;
		logic       cs_n;
		logic       busy;
		logic [7:0] status_byte;
		logic       status_valid;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       write_wanted;
		logic       done;
	} result_t;

endpackage

// ===== hdl/srm_front.sv =====
// Front end: decodes each incoming item and builds the header byte for starts.
// Depends on srm_pkg.
`timescale 1ns / 1ps

module srm_front (
	input  srm_pkg::cfg_t  cfg,
	input  logic [1:0]     cmd,
	input  logic [2:0]     access_kind,
	input  logic           read_flag,
	input  logic [7:0]     address,
	input  logic [7:0]     byte_count,
	input  logic [7:0]     write_byte,
	input  logic           miso_bit,
	output srm_pkg::item_t item
);
	import srm_pkg::*;

	logic [5:0] code;
	logic       burst;

	always_comb begin
		case (access_kind)
			KIND_EXT:     code = cfg.ext_code;
			KIND_DIRFIFO: code = cfg.dir_code;
			KIND_STDFIFO: code = cfg.std_code;
			default:      code = address[5:0];
		endcase
		burst = (access_kind != KIND_STROBE) && (byte_count > 8'd1);

		item.kind  = access_kind;
		item.rd    = read_flag;
		item.head  = {read_flag, burst, code};
		item.addr  = address;
		item.count = byte_count;
		item.wbyte = write_byte;
		item.miso  = miso_bit;
		case (cmd)
			CMD_TICK:  item.op = OP_TICK;
			CMD_START: item.op = (access_kind <= KIND_STDFIFO) ? OP_START : OP_NOP;
			CMD_LOAD:  item.op = OP_LOAD;
			default:   item.op = OP_NOP;
		endcase
	end

endmodule

// ===== hdl/srm_queue.sv =====
// Two-entry item queue between front end and serial engine.
// Depends on srm_pkg.
`timescale 1ns / 1ps

module srm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srm_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output srm_pkg::item_t head_item
);
	import srm_pkg::*;

	item_t      ent_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full       = (cnt_q == 2'(QDEPTH));
	assign head_valid = (cnt_q != 2'd0);
	assign head_item  = ent_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/srm_back.sv =====
// Serial engine: runs the access state machine, one item per cycle while the result
// side does not stall, with a registered result stage. Depends on srm_pkg.
`timescale 1ns / 1ps

module srm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  srm_pkg::item_t   q_item,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output srm_pkg::result_t res
);
	import srm_pkg::*;

	phase_t     phase_q, n_phase;
	logic [2:0] bit_q, n_bit, bit_dec;
	logic [7:0] tx_q, n_tx;
	logic [7:0] rx_q, n_rx;
	logic [7:0] left_q, n_left;
	logic [2:0] kind_q, n_kind;
	logic       rd_q, n_rd;
	logic [7:0] addr_q, n_addr;
	logic [7:0] whold_q, n_whold;
	logic       wfull_q, n_wfull;
	logic       sclk_q, n_sclk;
	logic       mosi_q, n_mosi;
	logic       cs_n_q, n_cs_n;
	logic       st_v, rd_v, done, go_data, rd_data;

	logic    out_valid_q;
	result_t res_q;

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign bit_dec   = bit_q - 3'd1;
	assign rd_data   = (phase_q == PH_DATA) && rd_q;

	always_comb begin
		n_phase = phase_q;
		n_bit   = bit_q;
		n_tx    = tx_q;
		n_rx    = rx_q;
		n_left  = left_q;
		n_kind  = kind_q;
		n_rd    = rd_q;
		n_addr  = addr_q;
		n_whold = whold_q;
		n_wfull = wfull_q;
		n_sclk  = sclk_q;
		n_mosi  = mosi_q;
		n_cs_n  = cs_n_q;
		st_v    = 1'b0;
		rd_v    = 1'b0;
		done    = 1'b0;
		go_data = 1'b0;
		case (q_item.op)
			OP_LOAD: begin
				n_whold = q_item.wbyte;
				n_wfull = 1'b1;
			end
			OP_START: begin
				if (phase_q == PH_IDLE) begin
					n_kind  = q_item.kind;
					n_rd    = q_item.rd;
					n_addr  = q_item.addr;
					n_left  = q_item.count;
					n_cs_n  = 1'b0;
					n_sclk  = 1'b0;
					n_tx    = q_item.head;
					n_bit   = 3'd7;
					n_mosi  = q_item.head[7];
					n_phase = PH_HEAD;
				end
			end
			OP_TICK: begin
				if (phase_q == PH_WAITW) begin
					if (wfull_q) begin
						n_wfull = 1'b0;
						n_tx    = whold_q;
						n_bit   = 3'd7;
						n_mosi  = whold_q[7];
						n_phase = PH_DATA;
					end
				end else if (phase_q != PH_IDLE) begin
					if (!sclk_q) begin
						n_sclk = 1'b1;
						if (phase_q == PH_HEAD || rd_data) begin
							n_rx[bit_q] = q_item.miso;
						end
					end else begin
						n_sclk = 1'b0;
						if (bit_q != 3'd0) begin
							n_bit = bit_dec;
							if (!rd_data) begin
								n_mosi = tx_q[bit_dec];
							end
						end else if (phase_q == PH_HEAD) begin
							st_v = 1'b1;
							if (kind_q == KIND_STROBE) begin
								done = 1'b1;
							end else if (kind_q == KIND_EXT || kind_q == KIND_DIRFIFO) begin
								n_tx    = addr_q;
								n_bit   = 3'd7;
								n_mosi  = addr_q[7];
								n_phase = PH_ADDR;
							end else begin
								go_data = 1'b1;
							end
						end else begin
							rd_v    = rd_data;
							go_data = 1'b1;
						end
						if (go_data) begin
							if (left_q == 8'd0) begin
								done = 1'b1;
							end else begin
								n_left = left_q - 8'd1;
								if (rd_q) begin
									n_bit   = 3'd7;
									n_phase = PH_DATA;
								end else if (wfull_q) begin
									n_wfull = 1'b0;
									n_tx    = whold_q;
									n_bit   = 3'd7;
									n_mosi  = whold_q[7];
									n_phase = PH_DATA;
								end else begin
									n_phase = PH_WAITW;
								end
							end
						end
						if (done) begin
							n_phase = PH_IDLE;
							n_bit   = 3'd7;
							n_cs_n  = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_q       <= 3'd7;
			tx_q        <= 8'd0;
			rx_q        <= 8'd0;
			left_q      <= 8'd0;
			kind_q      <= 3'd0;
			rd_q        <= 1'b0;
			addr_q      <= 8'd0;
			whold_q     <= 8'd0;
			wfull_q     <= 1'b0;
			sclk_q      <= 1'b0;
			mosi_q      <= 1'b1;
			cs_n_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= n_phase;
				bit_q   <= n_bit;
				tx_q    <= n_tx;
				rx_q    <= n_rx;
				left_q  <= n_left;
				kind_q  <= n_kind;
				rd_q    <= n_rd;
				addr_q  <= n_addr;
				whold_q <= n_whold;
				wfull_q <= n_wfull;
				sclk_q  <= n_sclk;
				mosi_q  <= n_mosi;
				cs_n_q  <= n_cs_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.sclk         <= n_sclk;
			res_q.mosi         <= n_mosi;
			res_q.cs_n         <= n_cs_n;
			res_q.busy         <= (n_phase != PH_IDLE);
			res_q.status_byte  <= st_v ? n_rx : 8'd0;
			res_q.status_valid <= st_v;
			res_q.read_byte    <= rd_v ? n_rx : 8'd0;
			res_q.read_valid   <= rd_v;
			res_q.write_wanted <= (n_phase == PH_WAITW);
			res_q.done         <= done;
		end
	end

endmodule

// ===== hdl/spi_radio_access_master.sv =====
// Top level of the SPI radio access master: config registers, front end,
// item queue and serial engine. Depends on srm_pkg and assert_macros.svh.
//
//   channel  | handshake            | carries
//   ---------+----------------------+---------------------------------------
//   in       | in_valid / in_ready  | cmd, access_kind, read_flag, address,
//            |                      | byte_count, write_byte, miso_bit
//   out      | out_valid/out_ready  | pin levels, status, read data, flags
//   apb      | psel/penable/pready  | three 6-bit header code registers
//
// One item per cycle sustained while the output does not stall; an accepted item
// is written into a queue entry, then its result into the result register, where
// it stays until taken.
// The two-entry queue and the result register let input and output stall
// independently. Reset is asynchronous, active low; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spi_radio_access_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [2:0]  access_kind,
	input  logic        read_flag,
	input  logic [7:0]  address,
	input  logic [7:0]  byte_count,
	input  logic [7:0]  write_byte,
	input  logic        miso_bit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        sclk,
	output logic        mosi,
	output logic        cs_n,
	output logic        busy_res,
	output logic [7:0]  status_byte,
	output logic        status_valid,
	output logic [7:0]  read_byte,
	output logic        read_valid,
	output logic        write_wanted,
	output logic        done_res
);
	import srm_pkg::*;

	cfg_t    cfg_q;
	item_t   front_item;
	item_t   q_item;
	logic    q_full;
	logic    q_valid;
	logic    pop;
	result_t res;
	logic    cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_ready = !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ext_code <= 6'd47;
			cfg_q.dir_code <= 6'd62;
			cfg_q.std_code <= 6'd63;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_EXT_CODE: cfg_q.ext_code <= pwdata[5:0];
				REG_DIR_CODE: cfg_q.dir_code <= pwdata[5:0];
				REG_STD_CODE: cfg_q.std_code <= pwdata[5:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_EXT_CODE: prdata = {26'd0, cfg_q.ext_code};
			REG_DIR_CODE: prdata = {26'd0, cfg_q.dir_code};
			REG_STD_CODE: prdata = {26'd0, cfg_q.std_code};
			default:      prdata = 32'd0;
		endcase
	end

	srm_front u_front (
		.cfg         (cfg_q),
		.cmd         (cmd),
		.access_kind (access_kind),
		.read_flag   (read_flag),
		.address     (address),
		.byte_count  (byte_count),
		.write_byte  (write_byte),
		.miso_bit    (miso_bit),
		.item        (front_item)
	);

	srm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid),
		.push_item  (front_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head_item  (q_item)
	);

	srm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign sclk         = res.sclk;
	assign mosi         = res.mosi;
	assign cs_n         = res.cs_n;
	assign busy_res     = res.busy;
	assign status_byte  = res.status_byte;
	assign status_valid = res.status_valid;
	assign read_byte    = res.read_byte;
	assign read_valid   = res.read_valid;
	assign write_wanted = res.write_wanted;
	assign done_res     = res.done;

	`ASSERT_IMPL(a_pop_has_item, clk, arst_n, pop, q_valid, "engine took from empty queue")
	`ASSERT_IMPL(a_done_ends, clk, arst_n, out_valid && done_res, cs_n && !busy_res && !sclk,
		"access end without chip select raised")
	`ASSERT_IMPL(a_one_byte_kind, clk, arst_n, out_valid, !(status_valid && read_valid),
		"status and read byte in one result")
	`ASSERT_NEXT(a_wait_held, clk, arst_n, out_valid && out_ready && write_wanted,
		!out_valid || busy_res || write_wanted || !sclk, "write wait left with clock high")

endmodule

// ===== dv/tb_spi_radio_access_master.sv =====
`timescale 1ns / 1ps
// Testbench for spi_radio_access_master: drives radio accesses, clock ticks and write
// bytes on the item channel and checks each result against an in-bench serial model.
// Depends on srm_pkg and the RTL under hdl/.

module tb_spi_radio_access_master;
	import srm_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [1:0]  cmd;
	logic [2:0]  access_kind;
	logic        read_flag;
	logic [7:0]  address, byte_count, write_byte;
	logic        miso_bit;
	logic        out_valid, out_ready;
	logic        sclk, mosi, cs_n, busy_res;
	logic [7:0]  status_byte, read_byte;
	logic        status_valid, read_valid, write_wanted, done_res;

	spi_radio_access_master u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .access_kind(access_kind), .read_flag(read_flag),
		.address(address), .byte_count(byte_count), .write_byte(write_byte),
		.miso_bit(miso_bit),
		.out_valid(out_valid), .out_ready(out_ready),
		.sclk(sclk), .mosi(mosi), .cs_n(cs_n), .busy_res(busy_res),
		.status_byte(status_byte), .status_valid(status_valid),
		.read_byte(read_byte), .read_valid(read_valid),
		.write_wanted(write_wanted), .done_res(done_res)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// serial engine model
	cfg_t       codes;
	phase_t     m_phase;
	logic [2:0] m_bit;
	logic [7:0] m_tx, m_rx, m_left;
	logic [2:0] m_kind;
	logic       m_rd;
	logic [7:0] m_addr, m_hold;
	logic       m_hold_full;
	logic       m_sclk, m_mosi, m_cs_n;

	result_t spi_state_q[$];
	int      errors;
	int      items_sent;
	int      cycles;
	int      send_gap_pct;
	int      recv_stall_pct;
	int      hold_left;

	function automatic void model_reset();
		codes.ext_code = 6'd47;
		codes.dir_code = 6'd62;
		codes.std_code = 6'd63;
		m_phase = PH_IDLE;
		m_bit = 3'd7;
		m_tx = 8'd0;
		m_rx = 8'd0;
		m_left = 8'd0;
		m_kind = 3'd0;
		m_rd = 1'b0;
		m_addr = 8'd0;
		m_hold = 8'd0;
		m_hold_full = 1'b0;
		m_sclk = 1'b0;
		m_mosi = 1'b1;
		m_cs_n = 1'b1;
	endfunction

	function automatic void load_tx(input logic [7:0] value, input phase_t next_phase);
		m_tx = value;
		m_bit = 3'd7;
		m_mosi = value[7];
		m_phase = next_phase;
	endfunction

	function automatic void take_write_byte();
		m_hold_full = 1'b0;
		load_tx(m_hold, PH_DATA);
	endfunction

	// 1 when no data byte is left and the access ends
	function automatic logic open_data_byte();
		if (m_left == 8'd0)
			return 1'b1;
		m_left = m_left - 8'd1;
		if (m_rd) begin
			m_bit = 3'd7;
			m_phase = PH_DATA;
		end else if (m_hold_full) begin
			take_write_byte();
		end else begin
			m_phase = PH_WAITW;
		end
		return 1'b0;
	endfunction

	function automatic result_t next_spi_state(input logic [1:0] c, input logic [2:0] k,
			input logic r, input logic [7:0] a, input logic [7:0] n,
			input logic [7:0] wb, input logic miso);
		result_t    res;
		logic [7:0] head;
		logic       st, rv, fin;
		st = 1'b0;
		rv = 1'b0;
		fin = 1'b0;
		if (c == CMD_LOAD) begin
			m_hold = wb;
			m_hold_full = 1'b1;
		end else if (c == CMD_START) begin
			if (m_phase == PH_IDLE && k <= KIND_STDFIFO) begin
				head = {r, (k != KIND_STROBE) && (n > 8'd1), 6'd0};
				case (k)
					KIND_REG, KIND_STROBE: head[5:0] = a[5:0];
					KIND_EXT:              head[5:0] = codes.ext_code;
					KIND_DIRFIFO:          head[5:0] = codes.dir_code;
					default:               head[5:0] = codes.std_code;
				endcase
				m_kind = k;
				m_rd = r;
				m_addr = a;
				m_left = n;
				m_cs_n = 1'b0;
				m_sclk = 1'b0;
				load_tx(head, PH_HEAD);
			end
		end else if (c == CMD_TICK && m_phase != PH_IDLE) begin
			if (m_phase == PH_WAITW) begin
				if (m_hold_full)
					take_write_byte();
			end else if (!m_sclk) begin
				m_sclk = 1'b1;
				if (m_phase == PH_HEAD || (m_phase == PH_DATA && m_rd))
					m_rx[m_bit] = miso;
			end else begin
				m_sclk = 1'b0;
				if (m_bit != 3'd0) begin
					m_bit = m_bit - 3'd1;
					if (!(m_phase == PH_DATA && m_rd))
						m_mosi = m_tx[m_bit];
				end else if (m_phase == PH_HEAD) begin
					st = 1'b1;
					if (m_kind == KIND_STROBE)
						fin = 1'b1;
					else if (m_kind == KIND_EXT || m_kind == KIND_DIRFIFO)
						load_tx(m_addr, PH_ADDR);
					else
						fin = open_data_byte();
				end else begin
					rv = (m_phase == PH_DATA) && m_rd;
					fin = open_data_byte();
				end
				if (fin) begin
					m_phase = PH_IDLE;
					m_bit = 3'd7;
					m_cs_n = 1'b1;
				end
			end
		end
		res.sclk = m_sclk;
		res.mosi = m_mosi;
		res.cs_n = m_cs_n;
		res.busy = (m_phase != PH_IDLE);
		res.status_byte = st ? m_rx : 8'd0;
		res.status_valid = st;
		res.read_byte = rv ? m_rx : 8'd0;
		res.read_valid = rv;
		res.write_wanted = (m_phase == PH_WAITW);
		res.done = fin;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t ns: %s expected %0h got %0h", $realtime, field, want, got);
		errors++;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (spi_state_q.size() == 0) begin
				report_mismatch("unexpected item", 8'd0, 8'd0);
			end else begin
				want = spi_state_q.pop_front();
				if (sclk !== want.sclk)
					report_mismatch("sclk", 8'(want.sclk), 8'(sclk));
				if (mosi !== want.mosi)
					report_mismatch("mosi", 8'(want.mosi), 8'(mosi));
				if (cs_n !== want.cs_n)
					report_mismatch("cs_n", 8'(want.cs_n), 8'(cs_n));
				if (busy_res !== want.busy)
					report_mismatch("busy_res", 8'(want.busy), 8'(busy_res));
				if (status_byte !== want.status_byte)
					report_mismatch("status_byte", want.status_byte, status_byte);
				if (status_valid !== want.status_valid)
					report_mismatch("status_valid", 8'(want.status_valid), 8'(status_valid));
				if (read_byte !== want.read_byte)
					report_mismatch("read_byte", want.read_byte, read_byte);
				if (read_valid !== want.read_valid)
					report_mismatch("read_valid", 8'(want.read_valid), 8'(read_valid));
				if (write_wanted !== want.write_wanted)
					report_mismatch("write_wanted", 8'(want.write_wanted), 8'(write_wanted));
				if (done_res !== want.done)
					report_mismatch("done_res", 8'(want.done), 8'(done_res));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// called and left at a falling edge; valid stays up after acceptance
	task automatic send_item(input logic [1:0] c, input logic [2:0] k, input logic r,
			input logic [7:0] a, input logic [7:0] n, input logic [7:0] wb,
			input logic miso);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		access_kind <= k;
		read_flag <= r;
		address <= a;
		byte_count <= n;
		write_byte <= wb;
		miso_bit <= miso;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		spi_state_q.push_back(next_spi_state(c, k, r, a, n, wb, miso));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_cmd(input logic [1:0] c);
		logic [2:0] k;
		logic       r, miso;
		logic [7:0] a, n, wb;
		k = 3'($urandom);
		r = 1'($urandom);
		a = 8'($urandom);
		n = 8'($urandom);
		wb = 8'($urandom);
		miso = 1'($urandom);
		send_item(c, k, r, a, n, wb, miso);
	endtask

	task automatic send_start(input logic [2:0] k, input logic r, input logic [7:0] a,
			input logic [7:0] n);
		logic [7:0] wb;
		logic       miso;
		wb = 8'($urandom);
		miso = 1'($urandom);
		send_item(CMD_START, k, r, a, n, wb, miso);
	endtask

	// clocks the current access to its end, with write bytes and stray items mixed in
	task automatic finish_access(input int load_pct);
		int pick;
		while (m_phase != PH_IDLE) begin
			pick = $urandom_range(99);
			if (!m_rd && !m_hold_full && pick < load_pct)
				send_cmd(CMD_LOAD);
			else if (pick == 99)
				send_cmd(OP_NOP);
			else if (pick == 98)
				send_cmd(CMD_START);
			else if (pick == 97)
				send_cmd(CMD_LOAD);
			else
				send_cmd(CMD_TICK);
		end
	endtask

	task automatic run_access(input logic [2:0] k, input logic r, input logic [7:0] a,
			input logic [7:0] n, input int load_pct);
		send_start(k, r, a, n);
		finish_access(load_pct);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (spi_state_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		@(negedge clk);
	endtask

	// left at a falling edge with psel still high
	task automatic apb_write(input logic [1:0] idx, input logic [5:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {26'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_EXT_CODE: codes.ext_code = value;
			REG_DIR_CODE: codes.dir_code = value;
			default:      codes.std_code = value;
		endcase
		@(negedge clk);
	endtask

	task automatic program_codes(input logic [5:0] ext_val, input logic [5:0] dir_val,
			input logic [5:0] std_val);
		wait_drained();
		apb_write(REG_EXT_CODE, ext_val);
		apb_write(REG_DIR_CODE, dir_val);
		apb_write(REG_STD_CODE, std_val);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_idle_items();
		send_cmd(CMD_TICK);
		send_cmd(OP_NOP);
		send_start(3'd5, 1'b1, 8'hFF, 8'hFF);
		send_start(3'd6, 1'b0, 8'h00, 8'h00);
		send_start(3'd7, 1'b1, 8'hAA, 8'h02);
		send_cmd(CMD_LOAD);
		send_cmd(CMD_TICK);
	endtask

	task automatic test_each_access();
		run_access(KIND_STROBE, 1'b0, 8'hFF, 8'hFF, 50);
		run_access(KIND_STROBE, 1'b1, 8'h00, 8'h00, 50);
		run_access(KIND_REG, 1'b1, 8'hC0, 8'd1, 50);
		run_access(KIND_REG, 1'b0, 8'h3F, 8'd2, 50);
		run_access(KIND_EXT, 1'b1, 8'h00, 8'd0, 50);
		run_access(KIND_EXT, 1'b0, 8'hFF, 8'd1, 50);
		run_access(KIND_DIRFIFO, 1'b0, 8'hA5, 8'd3, 10);
		run_access(KIND_DIRFIFO, 1'b1, 8'h5A, 8'd0, 50);
		run_access(KIND_STDFIFO, 1'b1, 8'h81, 8'd2, 50);
		run_access(KIND_STDFIFO, 1'b0, 8'h7E, 8'd0, 50);
	endtask

	task automatic test_start_while_busy();
		send_start(KIND_REG, 1'b1, 8'h12, 8'd1);
		send_start(KIND_STROBE, 1'b0, 8'h34, 8'd0);
		send_cmd(CMD_TICK);
		send_start(KIND_EXT, 1'b0, 8'h56, 8'd3);
		finish_access(50);
	endtask

	task automatic test_write_stall();
		send_start(KIND_REG, 1'b0, 8'h15, 8'd2);
		while (m_phase != PH_WAITW)
			send_cmd(CMD_TICK);
		repeat (3)
			send_cmd(CMD_TICK);
		send_cmd(CMD_LOAD);
		finish_access(100);
	endtask

	task automatic test_code_extremes();
		program_codes(6'd0, 6'd0, 6'd0);
		run_access(KIND_EXT, 1'b1, 8'h3C, 8'd0, 50);
		run_access(KIND_DIRFIFO, 1'b0, 8'hC3, 8'd1, 50);
		run_access(KIND_STDFIFO, 1'b1, 8'h00, 8'd0, 50);
		program_codes(6'h3F, 6'h3F, 6'h3F);
		run_access(KIND_EXT, 1'b0, 8'hFF, 8'd0, 50);
		run_access(KIND_DIRFIFO, 1'b1, 8'h0F, 8'd0, 50);
		run_access(KIND_STDFIFO, 1'b0, 8'hF0, 8'd2, 50);
	endtask

	// receiver holds off while items keep coming, so the input side stalls
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		run_access(KIND_STDFIFO, 1'b1, 8'h00, 8'd4, 50);
	endtask

	task automatic test_long_burst();
		run_access(KIND_STDFIFO, 1'b1, 8'hFF, 8'd16, 50);
	endtask

	task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
		int         stop, pick, size_pick;
		logic [2:0] k;
		logic       r;
		logic [7:0] a, n;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		stop = items_sent + count;
		while (items_sent < stop) begin
			pick = $urandom_range(99);
			a = 8'($urandom);
			r = 1'($urandom);
			if (pick < 6) begin
				case ($urandom_range(3))
					0: send_cmd(CMD_TICK);
					1: send_cmd(OP_NOP);
					2: send_cmd(CMD_LOAD);
					default: begin
						k = 3'($urandom_range(7, 5));
						send_start(k, r, a, ~a);
					end
				endcase
			end else if (pick < 20) begin
				n = 8'($urandom);
				run_access(KIND_STROBE, r, a, n, 50);
			end else begin
				k = 3'($urandom_range(4));
				size_pick = $urandom_range(99);
				if (size_pick < 70)
					n = 8'($urandom_range(3));
				else if (size_pick < 95)
					n = 8'($urandom_range(10, 4));
				else
					n = 8'($urandom_range(24, 11));
				run_access(k, r, a, n, $urandom_range(90, 15));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'd0;
		pwdata = 32'd0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		access_kind = KIND_REG;
		read_flag = 1'b0;
		address = 8'd0;
		byte_count = 8'd0;
		write_byte = 8'd0;
		miso_bit = 1'b0;
		out_ready = 1'b0;
		errors = 0;
		items_sent = 0;
		cycles = 0;
		hold_left = 0;
		send_gap_pct = 10;
		recv_stall_pct = 75;
		model_reset();
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_items();
		test_each_access();
		test_start_while_busy();
		test_write_stall();
		test_code_extremes();
		test_backpressure();

		program_codes(6'($urandom), 6'($urandom), 6'($urandom));
		test_random_traffic(250, 10, 75);
		program_codes(6'($urandom), 6'($urandom), 6'($urandom));
		test_random_traffic(250, 75, 10);
		program_codes(6'd47, 6'd62, 6'd63);
		test_random_traffic(250, 0, 0);
		test_long_burst();

		wait_drained();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
